[hw/rtl/dewt_pkg.sv]
// shared types and constants for the dual encoder and wheel tachometer
// no dependencies; imported by dewt_mul, dewt_div, the top level and the testbench
package dewt_pkg;

	localparam int SPEED_W   = 16;
	localparam int SCALE_W   = 8;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 4;
	localparam int FRAC_W    = 6;
	localparam int SAT_LSB   = SPEED_W + FRAC_W;
	localparam int MUL_STEPS = SCALE_W;
	localparam int DIV_STEPS = SPEED_W;

	localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

	localparam logic [CFG_W-1:0]   WINDOW_MS_RST  = 16'd100;
	localparam logic [CFG_W-1:0]   TIMEOUT_MS_RST = 16'd5000;
	localparam logic [CFG_W-1:0]   WHEEL_K_RST    = 16'd60000;
	localparam logic [SCALE_W-1:0] SCALE_RST      = 8'd75;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_MS  = 4'd0,
		CFG_TIMEOUT_MS = 4'd1,
		CFG_WHEEL_K    = 4'd2,
		CFG_SCALE      = 4'd3
	} cfg_reg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

[hw/rtl/dewt_mul.sv]
// shift-add multiplier, one multiplier bit per cycle
// depends on dewt_pkg
module dewt_mul import dewt_pkg::*; #(
	parameter int COUNT_WIDTH = 20
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [COUNT_WIDTH-1:0]       mcand,
	input  logic [SCALE_W-1:0]           mplier,
	output logic [COUNT_WIDTH+SCALE_W-1:0] product,
	output unit_sts_t                    sts
);

	localparam int PW    = COUNT_WIDTH + SCALE_W;
	localparam int CNT_W = $clog2(MUL_STEPS);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(MUL_STEPS - 1);

	logic [PW-1:0]      acc_q;
	logic [PW-1:0]      mcand_q;
	logic [SCALE_W-1:0] mplier_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			acc_q    <= '0;
			mcand_q  <= PW'(mcand);
			mplier_q <= mplier;
		end else if (busy_q) begin
			if (mplier_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign product  = acc_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

[hw/rtl/dewt_div.sv]
// restoring divider, one quotient bit per cycle, 16 bit dividend
// depends on dewt_pkg
module dewt_div import dewt_pkg::*; #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  logic [SPEED_W-1:0]     dividend,
	input  logic [TIMER_WIDTH-1:0] divisor,
	output logic [SPEED_W-1:0]     quotient,
	output unit_sts_t              sts
);

	localparam int CNT_W = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_STEPS - 1);

	logic [TIMER_WIDTH-1:0] rem_q;
	logic [SPEED_W-1:0]     quo_q;
	logic [TIMER_WIDTH-1:0] dvs_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [TIMER_WIDTH:0]   trial;
	logic [TIMER_WIDTH:0]   diff;
	logic                   fits;

	// remainder stays below the divisor, so one extra bit covers the shifted trial
	assign trial = {rem_q, quo_q[SPEED_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[TIMER_WIDTH-1:0] : trial[TIMER_WIDTH-1:0];
			quo_q <= {quo_q[SPEED_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

[hw/rtl/dual_encoder_and_wheel_tachometer_top.sv]
// Dual encoder and wheel tachometer. Input channel (in_valid/in_ready) takes one
// sample per beat: encoder_a_level, encoder_b_level, wheel_level, ms_tick. Edge
// counters and the ms timers update in the accept cycle. When the window timer
// reaches window_ms the block emits one report beat on out_valid/out_ready:
// scaled motor speeds, wheel speed (zero past the timeout) and the raw count of
// motor one. A rising wheel edge reloads wheel speed as wheel_constant / period.
// A sample with no report and no wheel edge leaves in_ready high. A report goes
// through the shared shift-add multiplier twice, once per motor, then loads the
// output register; without a wheel edge in_ready rises together with out_valid.
// A wheel edge runs the 16 step serial divider, after the report when the same
// sample also reports; a zero period skips the divider and saturates the speed.
// No new sample is taken while either unit runs. Configuration (cfg_valid,
// cfg_ready, cfg_index, cfg_data) is always ready; the user is to write it
// between samples, which the block does not enforce. Unknown indexes are dropped.
// Reset clears counters, timers, wheel speed and the output valid, and loads
// the default register values. The output register decouples the receiver:
// a stalled report holds, idle samples are still taken, and a following
// report waits in the sequencer until the output register is free.
// depends on dewt_pkg, dewt_mul, dewt_div
module dual_encoder_and_wheel_tachometer_top import dewt_pkg::*; #(
	parameter int COUNT_WIDTH = 20,
	parameter int TIMER_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 encoder_a_level,
	input  logic                 encoder_b_level,
	input  logic                 wheel_level,
	input  logic                 ms_tick,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [SPEED_W-1:0]   motor_a_speed,
	output logic [SPEED_W-1:0]   motor_b_speed,
	output logic [SPEED_W-1:0]   wheel_speed_out,
	output logic [SPEED_W-1:0]   motor_a_raw,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int PW    = COUNT_WIDTH + SCALE_W;
	localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_A,
		S_MUL_B,
		S_REPORT,
		S_DIV
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0]   window_ms_q;
	logic [CFG_W-1:0]   timeout_ms_q;
	logic [CFG_W-1:0]   wheel_k_q;
	logic [SCALE_W-1:0] scale_q;

	logic [COUNT_WIDTH-1:0] cnt_a_q;
	logic [COUNT_WIDTH-1:0] cnt_b_q;
	logic [COUNT_WIDTH-1:0] rep_a_q;
	logic [COUNT_WIDTH-1:0] rep_b_q;
	logic [TIMER_WIDTH-1:0] win_q;
	logic [TIMER_WIDTH-1:0] whl_q;
	logic [TIMER_WIDTH-1:0] period_q;
	logic [SPEED_W-1:0]     wheel_speed_q;
	logic [SPEED_W-1:0]     spd_a_q;
	logic [SPEED_W-1:0]     spd_b_q;
	logic                   seen_q;
	logic                   prev_a_q;
	logic                   prev_b_q;
	logic                   timeout_q;
	logic                   edge_q;
	logic                   mul_go_q;
	logic                   div_go_q;

	logic [COUNT_WIDTH-1:0] cnt_a_nx;
	logic [COUNT_WIDTH-1:0] cnt_b_nx;
	logic [TIMER_WIDTH-1:0] win_nx;
	logic [TIMER_WIDTH-1:0] whl_nx;
	logic                   report_now;
	logic                   timeout_now;
	logic                   edge_now;
	logic                   in_beat;
	logic                   out_free;
	logic                   out_load;
	logic                   mul_go_nx;
	logic                   div_go_nx;

	logic [COUNT_WIDTH-1:0] mul_mcand;
	logic [PW-1:0]          product;
	logic [SPEED_W-1:0]     product_sat;
	logic [SPEED_W-1:0]     quotient;
	unit_sts_t              mul_sts;
	unit_sts_t              div_sts;

	assign in_ready  = (state_q == S_IDLE);
	assign in_beat   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid || out_ready;
	assign out_load  = (state_q == S_REPORT) && out_free;

	// saturating edge counters and timers
	assign cnt_a_nx = (encoder_a_level && !prev_a_q && !(&cnt_a_q)) ? cnt_a_q + 1'b1 : cnt_a_q;
	assign cnt_b_nx = (encoder_b_level && !prev_b_q && !(&cnt_b_q)) ? cnt_b_q + 1'b1 : cnt_b_q;
	assign win_nx   = (ms_tick && !(&win_q)) ? win_q + 1'b1 : win_q;
	assign whl_nx   = (ms_tick && !(&whl_q)) ? whl_q + 1'b1 : whl_q;

	assign report_now  = CMP_W'(win_nx) >= CMP_W'(window_ms_q);
	assign timeout_now = CMP_W'(whl_nx) > CMP_W'(timeout_ms_q);
	assign edge_now    = wheel_level && !seen_q;

	// unit starts: first multiply on a reporting sample, second after the first;
	// divide on a wheel edge with a nonzero period, after the report if there is one
	assign mul_go_nx = (in_beat && report_now) || ((state_q == S_MUL_A) && mul_sts.done);
	assign div_go_nx = (in_beat && !report_now && edge_now && (whl_nx != '0))
		|| (out_load && edge_q && (period_q != '0));

	assign mul_mcand   = (state_q == S_MUL_A) ? rep_a_q : rep_b_q;
	// drop six fraction bits, clamp to 16 bits
	assign product_sat = (|product[PW-1:SAT_LSB]) ? SPEED_MAX : product[SAT_LSB-1:FRAC_W];

	dewt_mul #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go_q),
		.mcand  (mul_mcand),
		.mplier (scale_q),
		.product(product),
		.sts    (mul_sts)
	);

	dewt_div #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (div_go_q),
		.dividend(wheel_k_q),
		.divisor (period_q),
		.quotient(quotient),
		.sts     (div_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_ms_q  <= WINDOW_MS_RST;
			timeout_ms_q <= TIMEOUT_MS_RST;
			wheel_k_q    <= WHEEL_K_RST;
			scale_q      <= SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WINDOW_MS:  window_ms_q  <= cfg_data;
				CFG_TIMEOUT_MS: timeout_ms_q <= cfg_data;
				CFG_WHEEL_K:    wheel_k_q    <= cfg_data;
				CFG_SCALE:      scale_q      <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			cnt_a_q         <= '0;
			cnt_b_q         <= '0;
			rep_a_q         <= '0;
			rep_b_q         <= '0;
			win_q           <= '0;
			whl_q           <= '0;
			period_q        <= '0;
			wheel_speed_q   <= '0;
			spd_a_q         <= '0;
			spd_b_q         <= '0;
			seen_q          <= 1'b0;
			prev_a_q        <= 1'b0;
			prev_b_q        <= 1'b0;
			timeout_q       <= 1'b0;
			edge_q          <= 1'b0;
			mul_go_q        <= 1'b0;
			div_go_q        <= 1'b0;
			out_valid       <= 1'b0;
			motor_a_speed   <= '0;
			motor_b_speed   <= '0;
			wheel_speed_out <= '0;
			motor_a_raw     <= '0;
		end else begin
			mul_go_q <= mul_go_nx;
			div_go_q <= div_go_nx;
			if (out_load)
				out_valid <= 1'b1;
			else if (out_valid && out_ready)
				out_valid <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						prev_a_q  <= encoder_a_level;
						prev_b_q  <= encoder_b_level;
						seen_q    <= wheel_level;
						timeout_q <= timeout_now;
						edge_q    <= edge_now;
						period_q  <= whl_nx;
						whl_q     <= edge_now ? '0 : whl_nx;
						rep_a_q   <= cnt_a_nx;
						rep_b_q   <= cnt_b_nx;
						if (report_now) begin
							cnt_a_q <= '0;
							cnt_b_q <= '0;
							win_q   <= '0;
							state_q <= S_MUL_A;
						end else begin
							cnt_a_q <= cnt_a_nx;
							cnt_b_q <= cnt_b_nx;
							win_q   <= win_nx;
							if (edge_now)
								state_q <= S_DIV;
						end
					end
				end
				S_MUL_A: begin
					if (mul_sts.done) begin
						spd_a_q <= product_sat;
						state_q <= S_MUL_B;
					end
				end
				S_MUL_B: begin
					if (mul_sts.done) begin
						spd_b_q <= product_sat;
						state_q <= S_REPORT;
					end
				end
				S_REPORT: begin
					if (out_free) begin
						motor_a_speed   <= spd_a_q;
						motor_b_speed   <= spd_b_q;
						wheel_speed_out <= timeout_q ? '0 : wheel_speed_q;
						motor_a_raw     <= rep_a_q[SPEED_W-1:0];
						// a timed-out wheel stays at zero until its next edge
						if (timeout_q)
							wheel_speed_q <= '0;
						if (edge_q)
							state_q <= S_DIV;
						else
							state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (period_q == '0) begin
						wheel_speed_q <= SPEED_MAX;
						state_q       <= S_IDLE;
					end else if (div_sts.done) begin
						wheel_speed_q <= quotient;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_idle_units_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!mul_sts.busy && !div_sts.busy))
		else $error("sample accepted while an arithmetic unit is running");

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_sts.busy && div_sts.busy))
		else $error("multiplier and divider busy together");

	a_div_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |=> (state_q == S_IDLE))
		else $error("divider finished without returning to idle");

	a_report_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REPORT && out_free) |=> out_valid)
		else $error("report step left output register empty");
`endif

endmodule

[verif/tb_dual_encoder_and_wheel_tachometer_top.sv]
// self-checking testbench for dual_encoder_and_wheel_tachometer_top: pin samples in,
// window reports out, each report compared against a cycle-free tachometer predictor
// depends on dewt_pkg and the top level rtl only
module tb_dual_encoder_and_wheel_tachometer_top;
	import dewt_pkg::*;

	localparam int CNT_W         = 20;
	localparam int TMR_W         = 16;
	localparam int SETTLE_CYCLES = 60;
	localparam int RANDOM_ITEMS  = 400;
	localparam int PHASE_ITEMS   = 120;
	localparam int SAT_EDGES     = 60;
	localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_IDX = CFG_IDX_W'(CFG_SCALE + 1);

	typedef struct packed {
		logic [SPEED_W-1:0] a_speed;
		logic [SPEED_W-1:0] b_speed;
		logic [SPEED_W-1:0] wheel;
		logic [SPEED_W-1:0] a_raw;
	} report_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 encoder_a_level;
	logic                 encoder_b_level;
	logic                 wheel_level;
	logic                 ms_tick;
	logic                 out_valid;
	logic                 out_ready;
	logic [SPEED_W-1:0]   motor_a_speed;
	logic [SPEED_W-1:0]   motor_b_speed;
	logic [SPEED_W-1:0]   wheel_speed_out;
	logic [SPEED_W-1:0]   motor_a_raw;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// shadow registers and tachometer state
	logic [CFG_W-1:0]   cfg_window  = WINDOW_MS_RST;
	logic [CFG_W-1:0]   cfg_timeout = TIMEOUT_MS_RST;
	logic [CFG_W-1:0]   cfg_wheel_k = WHEEL_K_RST;
	logic [SCALE_W-1:0] cfg_scale   = SCALE_RST;
	logic [CNT_W-1:0]   cnt_a = '0;
	logic [CNT_W-1:0]   cnt_b = '0;
	logic [TMR_W-1:0]   win_ms = '0;
	logic [TMR_W-1:0]   rev_ms = '0;
	logic [SPEED_W-1:0] rev_speed = '0;
	logic               wheel_hi = 1'b0;
	logic               last_a = 1'b0;
	logic               last_b = 1'b0;

	report_t pending_reports[$];

	int tx_gap_max = 6;
	int rx_gap_max = 6;
	int rx_hold_req = 0;
	int samples_sent = 0;
	int reports_due = 0;
	int reports_checked = 0;
	int cfg_writes = 0;
	int mismatches = 0;

	dual_encoder_and_wheel_tachometer_top #(
		.COUNT_WIDTH(CNT_W),
		.TIMER_WIDTH(TMR_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.encoder_a_level(encoder_a_level),
		.encoder_b_level(encoder_b_level),
		.wheel_level(wheel_level),
		.ms_tick(ms_tick),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.motor_a_speed(motor_a_speed),
		.motor_b_speed(motor_b_speed),
		.wheel_speed_out(wheel_speed_out),
		.motor_a_raw(motor_a_raw),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("tb_dual_encoder_and_wheel_tachometer_top: done, errors");
		$finish;
	end

	function automatic logic [SPEED_W-1:0] count_to_speed(input logic [CNT_W-1:0] cnt);
		logic [CNT_W+SCALE_W-1:0] prod;
		prod = (cnt * cfg_scale) >> FRAC_W;
		return (prod > SPEED_MAX) ? SPEED_MAX : prod[SPEED_W-1:0];
	endfunction

	// one accepted sample: edges, timers, window report, then wheel edge
	function automatic void advance_tachometer(input logic a, input logic b,
			input logic w, input logic t);
		report_t rep;
		logic [TMR_W-1:0] period;
		if (a && !last_a && cnt_a != '1)
			cnt_a = cnt_a + 1'b1;
		if (b && !last_b && cnt_b != '1)
			cnt_b = cnt_b + 1'b1;
		last_a = a;
		last_b = b;
		if (t) begin
			if (win_ms != '1)
				win_ms = win_ms + 1'b1;
			if (rev_ms != '1)
				rev_ms = rev_ms + 1'b1;
		end
		if (win_ms >= cfg_window) begin
			if (rev_ms > cfg_timeout)
				rev_speed = '0;
			rep.a_speed = count_to_speed(cnt_a);
			rep.b_speed = count_to_speed(cnt_b);
			rep.wheel   = rev_speed;
			rep.a_raw   = cnt_a[SPEED_W-1:0];
			pending_reports.push_back(rep);
			reports_due++;
			cnt_a  = '0;
			cnt_b  = '0;
			win_ms = '0;
		end
		if (w && !wheel_hi) begin
			period = rev_ms;
			rev_ms = '0;
			if (period == '0)
				rev_speed = SPEED_MAX;
			else
				rev_speed = cfg_wheel_k / period;
			wheel_hi = 1'b1;
		end else if (!w && wheel_hi) begin
			wheel_hi = 1'b0;
		end
	endfunction

	function automatic void check_field(input string field, input logic [SPEED_W-1:0] want,
			input logic [SPEED_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : check_beat
		report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: report beat expected none, actual %0d %0d %0d %0d", $time,
					motor_a_speed, motor_b_speed, wheel_speed_out, motor_a_raw);
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				check_field("motor_a_speed", want.a_speed, motor_a_speed);
				check_field("motor_b_speed", want.b_speed, motor_b_speed);
				check_field("wheel_speed_out", want.wheel, wheel_speed_out);
				check_field("motor_a_raw", want.a_raw, motor_a_raw);
			end
			reports_checked++;
		end
	end

	// receiver pacing: random wait after each beat, long hold when requested
	initial begin : rx_pacing
		int wait_left;
		wait_left = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				wait_left = $urandom_range(0, rx_gap_max);
			if (rx_hold_req > 0) begin
				wait_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (wait_left > 0) begin
				out_ready <= 1'b0;
				wait_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_sample(input logic a, input logic b, input logic w, input logic t);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		encoder_a_level <= a;
		encoder_b_level <= b;
		wheel_level     <= w;
		ms_tick         <= t;
		do @(posedge clk); while (!in_ready);
		advance_tachometer(a, b, w, t);
		samples_sent++;
	endtask

	// drain all reports, then let a running divide finish
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_WINDOW_MS:  cfg_window  = data;
			CFG_TIMEOUT_MS: cfg_timeout = data;
			CFG_WHEEL_K:    cfg_wheel_k = data;
			CFG_SCALE:      cfg_scale   = data[SCALE_W-1:0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic set_config(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] tmo,
			input logic [CFG_W-1:0] k, input logic [CFG_W-1:0] scale);
		wait_idle();
		cfg_write(CFG_WINDOW_MS, win);
		cfg_write(CFG_TIMEOUT_MS, tmo);
		cfg_write(CFG_WHEEL_K, k);
		cfg_write(CFG_SCALE, scale);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_sample();
		send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// one full window with the register values left by reset
	task automatic test_reset_defaults();
		for (int i = 0; i < WINDOW_MS_RST; i++)
			send_sample(i[0], (i % 3) == 0, 1'b0, 1'b1);
	endtask

	// window of zero reports on every sample, ticking or not
	task automatic test_window_zero();
		set_config(16'd0, 16'hFFFF, 16'hFFFF, 16'h00FF);
		repeat (8) send_random_sample();
	endtask

	task automatic test_cfg_unknown();
		wait_idle();
		for (int idx = FIRST_UNUSED_IDX; idx < 2 ** CFG_IDX_W; idx++)
			cfg_write(CFG_IDX_W'(idx), CFG_W'($urandom));
		cfg_valid <= 1'b0;
		repeat (4) send_random_sample();
	endtask

	task automatic test_wheel_cases();
		set_config(16'd1, 16'd3, 16'd1000, 16'd64);
		send_sample(1'b0, 1'b0, 1'b0, 1'b1);
		send_sample(1'b1, 1'b0, 1'b0, 1'b1);
		send_sample(1'b0, 1'b0, 1'b1, 1'b0);
		// line held high: no new edge
		send_sample(1'b0, 1'b1, 1'b1, 1'b1);
		send_sample(1'b1, 1'b1, 1'b0, 1'b0);
		send_sample(1'b0, 1'b0, 1'b1, 1'b0);
		// edge with no tick since the last one
		send_sample(1'b0, 1'b0, 1'b0, 1'b0);
		send_sample(1'b0, 1'b0, 1'b1, 1'b0);
		// run past the timeout so the report zeros the speed
		repeat (5) send_sample(1'b0, 1'b0, 1'b0, 1'b1);
		set_config(16'd1, 16'hFFFF, 16'd0, 16'd64);
		send_sample(1'b0, 1'b0, 1'b1, 1'b0);
		send_sample(1'b0, 1'b0, 1'b0, 1'b0);
		send_sample(1'b0, 1'b0, 1'b1, 1'b0);
		send_sample(1'b0, 1'b0, 1'b0, 1'b1);
		send_sample(1'b0, 1'b0, 1'b0, 1'b0);
		send_sample(1'b0, 1'b0, 1'b1, 1'b1);
		send_sample(1'b0, 1'b0, 1'b0, 1'b1);
	endtask

	// long window at the top scale and constant: counts build up, one wheel edge,
	// then a short window forces the report
	task automatic test_saturation();
		tx_gap_max = 0;
		rx_gap_max = 0;
		set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF);
		for (int i = 0; i < 2 * SAT_EDGES; i++)
			send_sample(i[0], i[0], 1'b0, 1'b0);
		send_sample(1'b0, 1'b0, 1'b1, 1'b1);
		set_config(16'd1, 16'hFFFF, 16'hFFFF, 16'h00FF);
		send_sample(1'b0, 1'b0, 1'b0, 1'b1);
		tx_gap_max = 6;
		rx_gap_max = 6;
	endtask

	// long receiver stall with a report per sample: output and sequencer fill up
	task automatic test_backpressure();
		set_config(16'd0, 16'd40, CFG_W'($urandom), CFG_W'($urandom));
		tx_gap_max = 0;
		rx_gap_max = 0;
		rx_hold_req = 300;
		repeat (30) send_random_sample();
		tx_gap_max = 6;
		rx_gap_max = 6;
	endtask

	task automatic test_random();
		int phase;
		int items;
		int first_report;
		logic wheel_lvl;
		phase = 0;
		items = 0;
		first_report = reports_due;
		wheel_lvl = 1'b0;
		while ((items < RANDOM_ITEMS || reports_due - first_report < 40) && phase < 30) begin
			case (phase)
				0: set_config(16'd1, 16'd0, 16'd1, 16'd0);
				1: set_config(16'd2, 16'hFFFF, 16'hFFFF, 16'h00FF);
				default: set_config(
					CFG_W'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 12)
						: $urandom_range(0, 40)),
					CFG_W'(($urandom_range(0, 3) == 0) ? 32'hFFFF : $urandom_range(0, 30)),
					CFG_W'($urandom), CFG_W'($urandom));
			endcase
			tx_gap_max = (phase % 3 == 2) ? 0 : 6;
			rx_gap_max = (phase % 4 == 3) ? 0 : 6;
			repeat (PHASE_ITEMS) begin
				// wheel line mostly held for several samples, sometimes chattering
				if ($urandom_range(0, 7) == 0 || phase % 5 == 4)
					wheel_lvl = ~wheel_lvl;
				send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), wheel_lvl,
					$urandom_range(0, 3) != 0);
				items++;
			end
			phase++;
		end
		tx_gap_max = 6;
		rx_gap_max = 6;
	endtask

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		encoder_a_level = 1'b0;
		encoder_b_level = 1'b0;
		wheel_level     = 1'b0;
		ms_tick         = 1'b0;
		cfg_valid       = 1'b0;
		cfg_index       = CFG_WINDOW_MS;
		cfg_data        = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_window_zero();
		test_cfg_unknown();
		test_wheel_cases();
		test_saturation();
		test_backpressure();
		test_random();
		wait_idle();
		$display("run covered %0d samples and %0d register writes; %0d reports checked",
			samples_sent, cfg_writes, reports_checked);
		$display("mismatches seen: %0d", mismatches);
		if (mismatches == 0 && pending_reports.size() == 0)
			$display("tb_dual_encoder_and_wheel_tachometer_top: done, clean");
		else
			$display("tb_dual_encoder_and_wheel_tachometer_top: done, errors");
		$finish;
	end

endmodule
